FILE: src/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, idle while reset is high.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bba_pkg.sv
package bba_pkg;

  localparam int GRAN_BITS    = 15;
  localparam int LINK_W       = 16;
  localparam int HDR_W        = 6;
  localparam int LVL_W        = 4;
  localparam int BYTES_W      = 21;
  localparam int OFF_W        = 20;
  localparam int MIN_SHIFT    = 5;
  localparam int LEVEL_COUNT  = 16;

  localparam logic [LINK_W-1:0]  LINK_NIL     = 16'hFFFF;
  localparam logic [LVL_W-1:0]   LEVEL_TOP    = 4'd15;
  localparam logic [BYTES_W-1:0] HEAP_LIMIT   = 21'h100000;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = 21'h1FFFFF;
  localparam logic [OFF_W-1:0]   HEADER_BYTES = 20'd24;

  // Header bits: valid, free, level.
  localparam int HDR_VALID = 5;
  localparam int HDR_FREE  = 4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREE_REJ   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT, S_IDLE,
    S_A_PREP, S_A_FIND, S_A_SPLIT, S_A_SPLIT_RD, S_A_PUSHB, S_A_PUSHG,
    S_A_TAKE, S_A_TAKE_RD,
    S_F_CHECK, S_F_HDR, S_F_MERGE, S_F_BUD, S_F_WALK, S_F_WALK_RD,
    S_F_JOIN, S_F_PUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [GRAN_BITS-1:0] waddr;
    logic [LINK_W-1:0]    wdata;
    logic [GRAN_BITS-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic                 we;
    logic [GRAN_BITS-1:0] waddr;
    logic [HDR_W-1:0]     wdata;
    logic [GRAN_BITS-1:0] raddr;
  } hdr_req_t;

  // Block size in bytes for a level.
  function automatic logic [BYTES_W-1:0] level_size(input logic [LVL_W-1:0] lv);
    level_size = BYTES_W'(32) << lv;
  endfunction

  // Largest level whose block fits the heap.
  function automatic logic [LVL_W-1:0] top_level(input logic [BYTES_W-1:0] size);
    logic [LVL_W-1:0] t;
    t = '0;
    for (int i = 0; i < LEVEL_COUNT - 1; i++) begin
      if ((22'(64) << i) <= {1'b0, size}) t = LVL_W'(i + 1);
    end
    top_level = t;
  endfunction

endpackage

FILE: src/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 16,
  parameter int ABITS = 15
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**ABITS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bba_ctrl.sv
module bba_ctrl
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [BYTES_W-1:0]   alloc_bytes,
  input  logic [OFF_W-1:0]     free_offset,
  input  logic                 cfg_we,
  input  logic [BYTES_W-1:0]   heap_bytes,
  output logic                 done,
  output logic [1:0]           status,
  output logic [OFF_W-1:0]     payload_offset,
  output logic [LVL_W-1:0]     block_level,
  output logic [BYTES_W-1:0]   bytes_in_use,
  output logic [BYTES_W-1:0]   bytes_free,
  output link_req_t            link_req,
  input  logic [LINK_W-1:0]    link_rdata,
  output hdr_req_t             hdr_req,
  input  logic [HDR_W-1:0]     hdr_rdata
);

  state_t state, state_next;

  logic [BYTES_W-1:0]   heap_reg;
  logic [LINK_W-1:0]    heads [LEVEL_COUNT];
  logic [BYTES_W-1:0]   in_use;
  logic [GRAN_BITS-1:0] clr_addr;
  logic [BYTES_W-1:0]   abytes;
  logic [OFF_W-1:0]     foff;
  logic [LVL_W-1:0]     want;
  logic                 afail;
  logic [LVL_W-1:0]     lv;
  logic [GRAN_BITS-1:0] g;
  logic [GRAN_BITS-1:0] b;
  logic [GRAN_BITS-1:0] bg;
  logic [LINK_W-1:0]    cur;
  logic [LINK_W-1:0]    prev;
  logic [LINK_W-1:0]    cnt;
  logic [1:0]           st_r;
  logic [OFF_W-1:0]     off_r;
  logic [LVL_W-1:0]     lvl_r;

  logic [BYTES_W-1:0]   heap_eff;
  logic [LVL_W-1:0]     top_lv;
  logic [LVL_W-1:0]     hidx;
  logic [LINK_W-1:0]    head_rd;
  logic [21:0]          need;
  logic [LVL_W-1:0]     want_c;
  logic [LVL_W-1:0]     find_lv;
  logic                 find_ok;
  logic [LVL_W-1:0]     lv_dn;
  logic [LVL_W-1:0]     lv_up;
  logic [LINK_W-1:0]    bsum;
  logic [OFF_W-1:0]     hoff;
  logic [BYTES_W-1:0]   bo;
  logic [21:0]          add_sum;
  logic [GRAN_BITS-1:0] gmin;

  // Clamp the heap register and find the top level
  assign heap_eff = (heap_reg > HEAP_LIMIT) ? HEAP_LIMIT : heap_reg;
  assign top_lv   = top_level(heap_eff);

  assign lv_dn = lv - LVL_W'(1);
  assign lv_up = lv + LVL_W'(1);

  // Single head read port, index chosen per state
  always_comb begin
    unique case (state)
      S_A_PUSHB, S_A_PUSHG:   hidx = lv_dn;
      S_A_TAKE, S_A_TAKE_RD:  hidx = want;
      default:                hidx = lv;
    endcase
  end
  assign head_rd = heads[hidx];

  // Size the request
  assign need = {1'b0, abytes} + 22'd24;
  always_comb begin
    want_c = LEVEL_TOP;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if ({1'b0, level_size(LVL_W'(i))} >= need) want_c = LVL_W'(i);
    end
  end

  // Smallest non-empty list at or above the wanted level
  always_comb begin
    find_ok = 1'b0;
    find_lv = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (LVL_W'(i) >= want && !heads[i][LINK_W-1]) begin
        find_ok = 1'b1;
        find_lv = LVL_W'(i);
      end
    end
  end

  assign bsum      = {1'b0, g} + (LINK_W'(1) << lv_dn);
  assign hoff      = foff - HEADER_BYTES;
  assign bo        = {1'b0, g, 5'b0} ^ level_size(lv);
  assign add_sum   = {1'b0, in_use} + {1'b0, level_size(want)};
  assign gmin      = (bg < g) ? bg : g;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:      if (&clr_addr) state_next = S_INIT;
      S_INIT:       state_next = S_IDLE;
      S_IDLE:       if (start) state_next = req_type ? S_F_CHECK : S_A_PREP;
      S_A_PREP:     state_next = S_A_FIND;
      S_A_FIND:     state_next = (afail || !find_ok) ? S_DONE : S_A_SPLIT;
      S_A_SPLIT: begin
        if (lv > want && !head_rd[LINK_W-1]) state_next = S_A_SPLIT_RD;
        else state_next = S_A_TAKE;
      end
      S_A_SPLIT_RD: state_next = bsum[LINK_W-1] ? S_A_PUSHG : S_A_PUSHB;
      S_A_PUSHB:    state_next = S_A_PUSHG;
      S_A_PUSHG:    state_next = S_A_SPLIT;
      S_A_TAKE:     state_next = head_rd[LINK_W-1] ? S_DONE : S_A_TAKE_RD;
      S_A_TAKE_RD:  state_next = S_DONE;
      S_F_CHECK: begin
        if (foff < HEADER_BYTES || hoff[4:0] != 5'd0) state_next = S_DONE;
        else state_next = S_F_HDR;
      end
      S_F_HDR:      state_next = hdr_rdata[HDR_VALID] ? S_F_MERGE : S_DONE;
      S_F_MERGE: begin
        if (lv == LEVEL_TOP || bo >= heap_eff) state_next = S_F_PUSH;
        else state_next = S_F_BUD;
      end
      S_F_BUD: begin
        if (!hdr_rdata[HDR_VALID] || !hdr_rdata[HDR_FREE] || hdr_rdata[3:0] != lv)
          state_next = S_F_PUSH;
        else state_next = S_F_WALK;
      end
      S_F_WALK: begin
        if (cnt[LINK_W-1] || cur[LINK_W-1]) state_next = S_F_JOIN;
        else state_next = S_F_WALK_RD;
      end
      S_F_WALK_RD:  state_next = (cur[GRAN_BITS-1:0] == bg) ? S_F_JOIN : S_F_WALK;
      S_F_JOIN:     state_next = S_F_MERGE;
      S_F_PUSH:     state_next = S_DONE;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
    if (cfg_we) state_next = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // Memory requests
  always_comb begin
    link_req = '0;
    hdr_req  = '0;
    unique case (state)
      S_CLEAR: begin
        hdr_req.we    = 1'b1;
        hdr_req.waddr = clr_addr;
      end
      S_INIT: begin
        hdr_req.we     = 1'b1;
        hdr_req.wdata  = {2'b11, top_lv};
        link_req.we    = 1'b1;
        link_req.wdata = LINK_NIL;
      end
      S_A_SPLIT, S_A_TAKE: begin
        link_req.raddr = head_rd[GRAN_BITS-1:0];
        hdr_req.raddr  = head_rd[GRAN_BITS-1:0];
      end
      S_A_SPLIT_RD: begin
        hdr_req.we    = 1'b1;
        hdr_req.waddr = g;
        hdr_req.wdata = {hdr_rdata[HDR_VALID:HDR_FREE], lv_dn};
      end
      S_A_PUSHB: begin
        hdr_req.we     = 1'b1;
        hdr_req.waddr  = b;
        hdr_req.wdata  = {2'b11, lv_dn};
        link_req.we    = 1'b1;
        link_req.waddr = b;
        link_req.wdata = head_rd;
      end
      S_A_PUSHG, S_F_PUSH: begin
        link_req.we    = 1'b1;
        link_req.waddr = g;
        link_req.wdata = head_rd;
      end
      S_A_TAKE_RD: begin
        hdr_req.we    = 1'b1;
        hdr_req.waddr = g;
        hdr_req.wdata = {hdr_rdata[HDR_VALID], 1'b0, hdr_rdata[3:0]};
      end
      S_F_CHECK: hdr_req.raddr = hoff[OFF_W-1:MIN_SHIFT];
      S_F_HDR: begin
        hdr_req.we    = hdr_rdata[HDR_VALID];
        hdr_req.waddr = g;
        hdr_req.wdata = hdr_rdata | (HDR_W'(1) << HDR_FREE);
      end
      S_F_MERGE: hdr_req.raddr = bo[OFF_W-1:MIN_SHIFT];
      S_F_WALK:  link_req.raddr = cur[GRAN_BITS-1:0];
      S_F_WALK_RD: begin
        link_req.we    = (cur[GRAN_BITS-1:0] == bg) && !prev[LINK_W-1];
        link_req.waddr = prev[GRAN_BITS-1:0];
        link_req.wdata = link_rdata;
      end
      S_F_JOIN: begin
        hdr_req.we    = 1'b1;
        hdr_req.waddr = gmin;
        hdr_req.wdata = {2'b11, lv_up};
      end
      default: ;
    endcase
  end

  // Datapath and list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_reg <= HEAP_LIMIT;
      in_use   <= '0;
      clr_addr <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) heads[i] <= LINK_NIL;
    end else if (cfg_we) begin
      heap_reg <= heap_bytes;
      in_use   <= '0;
      clr_addr <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) heads[i] <= LINK_NIL;
    end else begin
      case (state)
        S_CLEAR: clr_addr <= clr_addr + GRAN_BITS'(1);
        S_INIT:  heads[top_lv] <= '0;
        S_IDLE: begin
          abytes <= alloc_bytes;
          foff   <= free_offset;
          st_r   <= ST_OK;
          off_r  <= '0;
          lvl_r  <= '0;
        end
        S_A_PREP: begin
          want  <= want_c;
          afail <= (abytes == '0) || ({1'b0, level_size(want_c)} < need);
        end
        S_A_FIND: begin
          lv <= find_lv;
          if (afail || !find_ok) st_r <= ST_ALLOC_FAIL;
        end
        S_A_SPLIT: g <= head_rd[GRAN_BITS-1:0];
        S_A_SPLIT_RD: begin
          heads[lv] <= link_rdata;
          b         <= bsum[GRAN_BITS-1:0];
        end
        S_A_PUSHB: heads[lv_dn] <= {1'b0, b};
        S_A_PUSHG: begin
          heads[lv_dn] <= {1'b0, g};
          lv           <= lv_dn;
        end
        S_A_TAKE: begin
          g <= head_rd[GRAN_BITS-1:0];
          if (head_rd[LINK_W-1]) st_r <= ST_ALLOC_FAIL;
        end
        S_A_TAKE_RD: begin
          heads[want] <= link_rdata;
          in_use      <= add_sum[21] ? BYTES_MAX : add_sum[BYTES_W-1:0];
          off_r       <= {g, 5'b0} + HEADER_BYTES;
          lvl_r       <= want;
        end
        S_F_CHECK: begin
          g <= hoff[OFF_W-1:MIN_SHIFT];
          if (foff < HEADER_BYTES || hoff[4:0] != 5'd0) st_r <= ST_FREE_REJ;
        end
        S_F_HDR: begin
          lv <= hdr_rdata[3:0];
          if (!hdr_rdata[HDR_VALID]) st_r <= ST_FREE_REJ;
          else if (in_use > level_size(hdr_rdata[3:0]))
            in_use <= in_use - level_size(hdr_rdata[3:0]);
          else in_use <= '0;
        end
        S_F_MERGE: bg <= bo[OFF_W-1:MIN_SHIFT];
        S_F_BUD: begin
          cur  <= head_rd;
          prev <= LINK_NIL;
          cnt  <= '0;
        end
        S_F_WALK_RD: begin
          if (cur[GRAN_BITS-1:0] == bg) begin
            if (prev[LINK_W-1]) heads[lv] <= link_rdata;
          end else begin
            prev <= cur;
            cur  <= link_rdata;
            cnt  <= cnt + LINK_W'(1);
          end
        end
        S_F_JOIN: begin
          g  <= gmin;
          lv <= lv_up;
        end
        S_F_PUSH: begin
          heads[lv] <= {1'b0, g};
          lvl_r     <= lv;
        end
        default: ;
      endcase
    end
  end

  // Port outputs
  always_comb begin
    busy           = (state != S_IDLE);
    done           = (state == S_DONE);
    status         = st_r;
    payload_offset = off_r;
    block_level    = lvl_r;
    bytes_in_use   = in_use;
    bytes_free     = (heap_eff > in_use) ? heap_eff - in_use : '0;
  end

endmodule

FILE: src/buddy_block_allocator.sv
// Buddy block allocator over a heap of up to 1 MiB in 32-byte granules,
// sixteen levels of LIFO free lists. Pulse start while busy is low to
// issue one request; exactly one result follows, shown for one cycle with
// done high, and the receiver cannot hold it off. An allocate splits
// one level at a time down to the wanted level, and fails at once when
// the size is zero or too large or no free list can serve it. A free is
// rejected at its offset or header check; else, at each level, it looks
// at the buddy and merges while the buddy is free at the same level,
// walking that free list to unlink it. The walks run on the link and
// header memories, one read each a cycle, through registered read ports.
// After reset and after every write of heap_bytes the block sweeps the
// header memory with busy high before the first request is taken.
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [BYTES_W-1:0] alloc_bytes,
  input  logic [OFF_W-1:0]   free_offset,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] heap_bytes,
  output logic               done,
  output logic [1:0]         status,
  output logic [OFF_W-1:0]   payload_offset,
  output logic [LVL_W-1:0]   block_level,
  output logic [BYTES_W-1:0] bytes_in_use,
  output logic [BYTES_W-1:0] bytes_free
);

  link_req_t          link_req;
  hdr_req_t           hdr_req;
  logic [LINK_W-1:0]  link_rdata;
  logic [HDR_W-1:0]   hdr_rdata;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .req_type, .alloc_bytes, .free_offset,
    .cfg_we, .heap_bytes, .done, .status, .payload_offset, .block_level,
    .bytes_in_use, .bytes_free,
    .link_req, .link_rdata, .hdr_req, .hdr_rdata
  );

  // Free-list links, one per granule
  bba_ram #(.WIDTH(LINK_W), .ABITS(GRAN_BITS)) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  // Granule headers
  bba_ram #(.WIDTH(HDR_W), .ABITS(GRAN_BITS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_req.we),
    .waddr (hdr_req.waddr),
    .wdata (hdr_req.wdata),
    .raddr (hdr_req.raddr),
    .rdata (hdr_rdata)
  );

endmodule

FILE: src/bba_checker.sv
`include "assert_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status
);

  // A result only appears while a request is in flight
  `BBA_ASSERT(a_done_busy, done |-> busy, "result shown while idle")

  // An accepted item makes the block busy
  `BBA_ASSERT(a_start_busy, (start && !busy) |=> busy, "item accepted but not busy")

  // One result per item, never two in a row
  `BBA_ASSERT(a_one_result, done |=> !done, "result repeated")

  // Status code is one of the three defined
  `BBA_ASSERT(a_status_ok, done |-> (status <= ST_FREE_REJ), "undefined status")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import bba_pkg::*;
();

  localparam int unsigned GRANULES  = 32768;
  localparam int unsigned HDR_OFF   = 24;
  localparam int unsigned CYCLE_CAP = 20000000;

  typedef enum int {K_ALLOC, K_FREE, K_FREE_LIVE, K_CFG, K_PAUSE} item_kind_t;

  typedef struct {
    item_kind_t  kind;
    logic [20:0] bytes;
    logic [19:0] offset;
  } req_item_t;

  typedef struct {
    status_t     st;
    logic [19:0] off;
    logic [3:0]  lvl;
    logic [20:0] in_use;
    logic [20:0] avail;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = 1'b0;
  logic [20:0] alloc_bytes = '0;
  logic [19:0] free_offset = '0;
  logic cfg_we = 1'b0;
  logic [20:0] heap_bytes = 21'h100000;
  logic busy, done;
  logic [1:0] status;
  logic [19:0] payload_offset;
  logic [3:0] block_level;
  logic [20:0] bytes_in_use, bytes_free;

  // Allocator shadow state
  bit [15:0] free_heads [16];
  bit [15:0] links [GRANULES];
  bit [7:0] hdrs [GRANULES];
  int unsigned used_bytes;
  int unsigned shadow_heap;

  req_item_t pending_items [$];
  alloc_result_t expected_results [$];
  int unsigned live_offsets [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap = 5;
  req_item_t cur;

  buddy_block_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .alloc_bytes(alloc_bytes), .free_offset(free_offset), .cfg_we(cfg_we),
    .heap_bytes(heap_bytes), .done(done), .status(status),
    .payload_offset(payload_offset), .block_level(block_level),
    .bytes_in_use(bytes_in_use), .bytes_free(bytes_free)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned blk_size(int unsigned lv);
    return longint'(32) << lv;
  endfunction

  function automatic int unsigned eff_heap();
    return shadow_heap > 1048576 ? 1048576 : shadow_heap;
  endfunction

  function automatic void push_block(int unsigned lv, int unsigned g);
    if (lv >= 16 || g >= GRANULES) return;
    links[g] = free_heads[lv];
    free_heads[lv] = g[15:0];
  endfunction

  function automatic int unsigned pop_block(int unsigned lv);
    int unsigned g;
    if (lv >= 16) return 32'hFFFF;
    g = free_heads[lv];
    if (g >= GRANULES) return 32'hFFFF;
    free_heads[lv] = links[g];
    return g;
  endfunction

  // Unlink a buddy, following at most one link per granule
  function automatic void unlink_block(int unsigned lv, int unsigned g);
    int unsigned prev, c;
    prev = 32'hFFFF;
    if (lv >= 16) return;
    c = free_heads[lv];
    for (int unsigned n = 0; n < GRANULES && c < GRANULES; n++) begin
      if (c == g) begin
        if (prev == 32'hFFFF) free_heads[lv] = links[c];
        else links[prev] = links[c];
        return;
      end
      prev = c;
      c = links[c];
    end
  endfunction

  function automatic void rebuild_heap(logic [20:0] val);
    int unsigned lv;
    lv = 0;
    shadow_heap = val;
    for (int i = 0; i < 16; i++) free_heads[i] = 16'hFFFF;
    for (int i = 0; i < GRANULES; i++) begin
      links[i] = '0;
      hdrs[i] = '0;
    end
    used_bytes = 0;
    while ((blk_size(lv) << 1) <= eff_heap() && lv < 15) lv++;
    hdrs[0] = 8'hC0 | lv[7:0];
    links[0] = 16'hFFFF;
    free_heads[lv] = 0;
    live_offsets.delete();
  endfunction

  // Work out the result of one accepted request and queue it
  function automatic void predict_request(logic rt, logic [20:0] ab, logic [19:0] fo);
    alloc_result_t r;
    int unsigned heap, want, l, g, b, lv, h, bg;
    longint unsigned need, sum, bo;
    bit [7:0] hb;
    heap = eff_heap();
    r.st = ST_OK;
    r.off = '0;
    r.lvl = '0;
    if (rt == 1'b0) begin
      need = longint'(ab) + HDR_OFF;
      want = 0;
      while (blk_size(want) < need && want < 15) want++;
      l = want;
      while (l < 16 && free_heads[l] == 16'hFFFF) l++;
      if (ab == 0 || blk_size(want) < need || l >= 16) begin
        r.st = ST_ALLOC_FAIL;
      end else begin
        while (l > want) begin
          g = pop_block(l);
          if (g == 32'hFFFF) break;
          b = g + (1 << (l - 1));
          hdrs[g] = (hdrs[g] & 8'hC0) | 8'(l - 1);
          if (b < GRANULES) begin
            hdrs[b] = 8'hC0 | 8'(l - 1);
            push_block(l - 1, b);
          end
          push_block(l - 1, g);
          l--;
        end
        g = pop_block(want);
        if (g == 32'hFFFF) begin
          r.st = ST_ALLOC_FAIL;
        end else begin
          hdrs[g] = hdrs[g] & 8'hBF;
          sum = longint'(used_bytes) + blk_size(want);
          used_bytes = sum > 64'h1FFFFF ? 32'h1FFFFF : int'(sum);
          r.off = 20'(g * 32 + HDR_OFF);
          r.lvl = want[3:0];
          live_offsets.push_back(r.off);
        end
      end
    end else begin
      h = int'(fo) - HDR_OFF;
      g = h / 32;
      if (fo < HDR_OFF || h % 32 != 0 || g >= GRANULES || hdrs[g][7] == 1'b0) begin
        r.st = ST_FREE_REJ;
      end else begin
        lv = hdrs[g] & 8'h1F;
        hdrs[g] = hdrs[g] | 8'h40;
        used_bytes = longint'(used_bytes) > blk_size(lv) ? used_bytes - int'(blk_size(lv)) : 0;
        while (lv < 15) begin
          bo = (longint'(g) * 32) ^ blk_size(lv);
          if (bo >= heap || bo / 32 >= GRANULES) break;
          bg = int'(bo / 32);
          hb = hdrs[bg];
          if (hb[7] == 1'b0 || hb[6] == 1'b0 || (hb & 8'h1F) != lv) break;
          unlink_block(lv, bg);
          if (bg < g) g = bg;
          lv++;
          hdrs[g] = 8'hC0 | lv[7:0];
        end
        push_block(lv, g);
        r.lvl = lv[3:0];
        foreach (live_offsets[i]) begin
          if (live_offsets[i] == fo) begin
            live_offsets.delete(i);
            break;
          end
        end
      end
    end
    r.in_use = used_bytes[20:0];
    r.avail = heap > used_bytes ? 21'(heap - used_bytes) : '0;
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Driver: present items, hold start until taken, apply register writes when idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap <= 5;
    end else if (cfg_we) begin
      cfg_we <= 1'b0;
      gap <= 5;
    end else if (start && !busy) begin
      predict_request(req_type, alloc_bytes, free_offset);
      start <= 1'b0;
      gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    end else if (!start && gap > 0) begin
      gap <= gap - 1;
    end else if (!start && pending_items.size() > 0) begin
      cur = pending_items[0];
      if (cur.kind == K_CFG || cur.kind == K_PAUSE) begin
        if (expected_results.size() == 0) begin
          void'(pending_items.pop_front());
          if (cur.kind == K_CFG) begin
            cfg_we <= 1'b1;
            heap_bytes <= cur.bytes;
            rebuild_heap(cur.bytes);
          end
        end
      end else if (!busy) begin
        void'(pending_items.pop_front());
        if (cur.kind == K_FREE_LIVE && live_offsets.size() > 0)
          cur.offset = 20'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
        req_type <= (cur.kind != K_ALLOC);
        alloc_bytes <= cur.bytes;
        free_offset <= cur.offset;
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (payload_offset !== e.off) report_mismatch("payload_offset", payload_offset, e.off);
        if (block_level !== e.lvl) report_mismatch("block_level", block_level, e.lvl);
        if (bytes_in_use !== e.in_use) report_mismatch("bytes_in_use", bytes_in_use, e.in_use);
        if (bytes_free !== e.avail) report_mismatch("bytes_free", bytes_free, e.avail);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(item_kind_t k, logic [20:0] b, logic [19:0] o);
    req_item_t it;
    it.kind = k;
    it.bytes = b;
    it.offset = o;
    pending_items.push_back(it);
  endtask

  // Noise free: random offset that never lands on a header
  function automatic logic [19:0] bad_offset();
    logic [19:0] x;
    x = 20'($urandom);
    if (x[4:0] == 5'd24) x[0] = 1'b1;
    return x;
  endfunction

  task automatic add_random_phase(logic [20:0] heap, int n, bit with_pause);
    int sel;
    logic [20:0] b;
    add_item(K_CFG, heap, '0);
    for (int i = 0; i < n; i++) begin
      if (with_pause && i == n / 2) add_item(K_PAUSE, '0, '0);
      sel = $urandom_range(0, 99);
      if (sel < 52) begin
        case ($urandom_range(0, 9))
          0:       b = 21'($urandom_range(1, 1048576));
          1, 2:    b = 21'($urandom_range(1, 65536));
          default: b = 21'($urandom_range(1, 1000));
        endcase
        add_item(K_ALLOC, b, '0);
      end else if (sel < 90) begin
        add_item(K_FREE_LIVE, '0, bad_offset());
      end else if (sel < 95) begin
        add_item(K_ALLOC, 21'($urandom), '0);
      end else begin
        add_item(K_FREE, 21'($urandom), bad_offset());
      end
    end
  endtask

  initial begin
    rebuild_heap(21'h100000);
    // Directed: field extremes and failure cases on the reset heap
    add_item(K_ALLOC, 21'd0, '0);
    add_item(K_ALLOC, 21'd1, '0);
    add_item(K_ALLOC, 21'd8, '0);
    add_item(K_ALLOC, 21'd9, '0);
    add_item(K_ALLOC, 21'd1048552, '0);
    add_item(K_ALLOC, 21'd1048553, '0);
    add_item(K_ALLOC, 21'h1FFFFF, '0);
    add_item(K_FREE, '0, 20'd0);
    add_item(K_FREE, '0, 20'd25);
    add_item(K_FREE, '0, 20'hFFFF8);
    add_item(K_FREE, '0, 20'hFFFFF);
    add_item(K_FREE, '0, 20'd24 + 20'd64);
    // Double free of the same block
    add_item(K_FREE, '0, 20'd24 + 20'd64);
    add_item(K_FREE_LIVE, '0, 20'd1);
    // Whole heap in one block, then back
    add_item(K_CFG, 21'h100000, '0);
    add_item(K_ALLOC, 21'd1048552, '0);
    add_item(K_ALLOC, 21'd1, '0);
    add_item(K_FREE, '0, 20'd24);
    // Smallest heap, a heap below one granule, an oversized register
    add_item(K_CFG, 21'd32, '0);
    add_item(K_ALLOC, 21'd8, '0);
    add_item(K_ALLOC, 21'd1, '0);
    add_item(K_FREE, '0, 20'd24);
    add_item(K_CFG, 21'd20, '0);
    add_item(K_ALLOC, 21'd8, '0);
    add_item(K_CFG, 21'h1FFFFF, '0);
    add_item(K_ALLOC, 21'd1048552, '0);
    // Random phases over several heap sizes
    add_random_phase(21'h100000, 450, 1'b1);
    add_random_phase(21'd4096, 150, 1'b0);
    add_random_phase(21'd100000, 200, 1'b1);
    add_random_phase(21'd32, 50, 1'b0);
    add_random_phase(21'($urandom_range(32, 1048576)), 150, 1'b0);
    add_random_phase(21'h1FFFFF, 150, 1'b0);

    @(posedge clk);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/buddy_block_allocator.sv
src/bba_checker.sv
verif/tb_top.sv
